// ----- hdl/ptas_pkg.sv -----
// ----------------------------------------------------------------------------
// ptas_pkg
// Shared types and constants of the per-type allocation statistics block.
// ----------------------------------------------------------------------------
package ptas_pkg;

  localparam int unsigned NUM_TYPES        = 16;
  localparam int unsigned BYTE_COUNT_WIDTH = 48;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned TYPE_W  = 4;
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned OUTB_W  = 48;
  localparam int unsigned SLOT_W  = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef struct packed {
    logic [CNT_W-1:0]            alloc_cnt;
    logic [CNT_W-1:0]            free_cnt;
    logic [CNT_W-1:0]            live_cnt;
    logic [CNT_W-1:0]            peak_cnt;
    logic [BYTE_COUNT_WIDTH-1:0] alloc_bytes;
    logic [BYTE_COUNT_WIDTH-1:0] free_bytes;
    logic [BYTE_COUNT_WIDTH-1:0] live_bytes;
    logic [BYTE_COUNT_WIDTH-1:0] max_bytes;
  } stats_row_t;

  typedef struct packed {
    logic [CNT_W-1:0]  allocs_total;
    logic [CNT_W-1:0]  frees_total;
    logic [OUTB_W-1:0] bytes_allocated_total;
    logic [OUTB_W-1:0] bytes_freed_total;
    logic [CNT_W-1:0]  live_allocs;
    logic [OUTB_W-1:0] live_bytes;
    logic [CNT_W-1:0]  max_live_allocs;
    logic [OUTB_W-1:0] max_live_bytes;
    logic              free_without_alloc;
    logic              size_mismatch;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the incoming item
    logic commit;   // write back the row and load the result register
  } ctrl_cmd_t;

endpackage

// ----- hdl/ptas_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptas_ctrl
// Sequencer: takes an item, runs the update in the execute state and hands the
// result to the output register once it is free.
// ----------------------------------------------------------------------------
module ptas_ctrl
  import ptas_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o.capture = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.commit  = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: if (cmd_o.commit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase

    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/ptas_dp.sv -----
// ----------------------------------------------------------------------------
// ptas_dp
// Counter table, read-modify-write update logic and result register.
// ----------------------------------------------------------------------------
module ptas_dp
  import ptas_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_cmd_t         cmd_i,
  input  logic [OP_W-1:0]   op_i,
  input  logic [TYPE_W-1:0] type_index_i,
  input  logic [SIZE_W-1:0] size_i,
  output result_t           result_o
);

  stats_row_t row_q [NUM_TYPES];

  logic [OP_W-1:0]             op_q;
  logic [TYPE_W-1:0]           type_q;
  logic [BYTE_COUNT_WIDTH-1:0] size_q;
  result_t                     result_q;

  logic                        in_range;
  logic [SLOT_W-1:0]           slot;
  stats_row_t                  cur, upd;
  logic [CNT_W-1:0]            live_cnt_inc;
  logic [BYTE_COUNT_WIDTH-1:0] live_bytes_inc;
  logic                        no_alloc, mismatch;
  result_t                     result_d;

  assign in_range = (32'(type_q) < 32'(NUM_TYPES));
  assign slot     = SLOT_W'(type_q);

  always_comb begin
    cur            = in_range ? row_q[slot] : '0;
    upd            = cur;
    no_alloc       = 1'b0;
    mismatch       = 1'b0;
    live_cnt_inc   = cur.live_cnt + CNT_W'(1);
    live_bytes_inc = cur.live_bytes + size_q;

    case (op_q)
      OP_ALLOC: begin
        upd.alloc_cnt   = cur.alloc_cnt + CNT_W'(1);
        upd.alloc_bytes = cur.alloc_bytes + size_q;
        upd.live_cnt    = live_cnt_inc;
        upd.live_bytes  = live_bytes_inc;
        if (live_cnt_inc > cur.peak_cnt) upd.peak_cnt = live_cnt_inc;
        if (live_bytes_inc > cur.max_bytes) upd.max_bytes = live_bytes_inc;
      end
      OP_FREE: begin
        upd.free_cnt   = cur.free_cnt + CNT_W'(1);
        upd.free_bytes = cur.free_bytes + size_q;
        if (cur.live_cnt != '0) begin
          upd.live_cnt = cur.live_cnt - CNT_W'(1);
        end else begin
          no_alloc = 1'b1;
        end
        if (cur.live_bytes >= size_q) begin
          upd.live_bytes = cur.live_bytes - size_q;
        end else begin
          upd.live_bytes = '0;
          mismatch       = 1'b1;
        end
      end
      default: ;  // read and the spare code change nothing
    endcase

    // out-of-range slot: everything reads as zero, nothing is written
    if (!in_range) begin
      upd      = '0;
      no_alloc = 1'b0;
      mismatch = 1'b0;
    end

    result_d.allocs_total          = upd.alloc_cnt;
    result_d.frees_total           = upd.free_cnt;
    result_d.bytes_allocated_total = OUTB_W'(upd.alloc_bytes);
    result_d.bytes_freed_total     = OUTB_W'(upd.free_bytes);
    result_d.live_allocs           = upd.live_cnt;
    result_d.live_bytes            = OUTB_W'(upd.live_bytes);
    result_d.max_live_allocs       = upd.peak_cnt;
    result_d.max_live_bytes        = OUTB_W'(upd.max_bytes);
    result_d.free_without_alloc    = no_alloc;
    result_d.size_mismatch         = mismatch;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(NUM_TYPES); i++) begin
        row_q[i] <= '0;
      end
    end else if (cmd_i.commit && in_range) begin
      row_q[slot] <= upd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_i;
      type_q <= type_index_i;
      size_q <= BYTE_COUNT_WIDTH'(size_i);
    end
    if (cmd_i.commit) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

// ----- hdl/per_type_alloc_stats_top.sv -----
// ----------------------------------------------------------------------------
// per_type_alloc_stats_top
// Per-type allocation statistics table with stream input and output.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one event item (op and slot in tuser, size in tdata).
//   m_axis: one result item per event, the slot's counters after the update
//           plus the free-without-alloc and size-mismatch flags in tuser.
//   Result: an accepted item is captured into the input registers, and in the
//   execute state, once the output register is free, its result is registered.
//   Items are taken one at a time; the slot row is read, updated and written
//   back in the execute state, and the next item is taken after it.
//   The output register lets a new item be accepted while a result waits.
//   A stalled receiver holds the result; an item already in execute then
//   waits for the output register and no further item is taken.
//   Reset clears all counters of every slot at once and empties the output.
// ----------------------------------------------------------------------------
module per_type_alloc_stats_top
  import ptas_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // size[31:0]
  input  logic [5:0]   s_axis_tuser,   // op[1:0], type_index[5:2]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // allocs_total[31:0], frees_total[63:32], bytes_allocated_total[111:64],
  // bytes_freed_total[159:112], live_allocs[191:160], live_bytes[239:192],
  // max_live_allocs[271:240], max_live_bytes[319:272]
  output logic [319:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser    // free_without_alloc[0], size_mismatch[1]
);

  ctrl_cmd_t cmd;
  result_t   res;

  ptas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  ptas_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .op_i         (s_axis_tuser[1:0]),
    .type_index_i (s_axis_tuser[5:2]),
    .size_i       (s_axis_tdata),
    .result_o     (res)
  );

  assign m_axis_tdata = {res.max_live_bytes, res.max_live_allocs, res.live_bytes,
                         res.live_allocs, res.bytes_freed_total,
                         res.bytes_allocated_total, res.frees_total,
                         res.allocs_total};
  assign m_axis_tuser = {res.size_mismatch, res.free_without_alloc};

`ifndef SYNTHESIS
  // one item at a time: execute cycle follows every accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted during execute cycle");

  // the live count never passes its peak, wrap included
  a_peak_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[271:240] >= m_axis_tdata[191:160])
    else $error("live allocation count above its peak");

  // a size mismatch floors live bytes at zero
  a_mismatch_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[239:192] == 48'd0)
    else $error("size mismatch with nonzero live bytes");
`endif

endmodule
